// ===== rtl/upd_pkg.sv =====
// Shared types, character constants and the digit mapping for the URL percent decoder.
package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [5:0] LETTER_BASE = 6'd10;

    // Output queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // Results produced by one input item: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_upd_push;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HIGH = 3'b100
    } t_phase;

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = 6'(c - CH_UPPER_A) + LETTER_BASE;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = 6'(c - CH_LOWER_A) + LETTER_BASE;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 6'(c - CH_ZERO);
        end
        return v;
    endfunction

endpackage

// ===== rtl/upd_decode.sv =====
// Escape state machine and per-byte decode producing zero, one or two results.
module upd_decode
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_upd_push o_push
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic [5:0] w_high_digit;
    logic [5:0] w_low_digit;
    logic [7:0] w_value;
    logic [7:0] w_byte;
    logic       w_end;

    assign w_byte = i_item.in_byte;
    assign w_end  = i_item.end_of_string;

    assign w_high_digit = digit_value(r_held);
    assign w_low_digit  = digit_value(w_byte);

    // Only the low four bits of the high digit survive the multiply by sixteen mod 256.
    assign w_value = {w_high_digit[3:0], 4'b0000} + {2'b00, w_low_digit};

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        o_push  = '0;
        unique case (r_phase)
            PH_PCT: begin
                if (w_end) begin
                    // A percent sign cut short by the end of the string passes through.
                    o_push.count  = 2'd2;
                    o_push.first  = '{out_byte: CH_PERCENT, out_last: 1'b0};
                    o_push.second = '{out_byte: (w_byte == CH_PLUS) ? CH_SPACE : w_byte,
                                      out_last: 1'b1};
                    n_phase = PH_IDLE;
                end else begin
                    n_held  = w_byte;
                    n_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                o_push.count = 2'd1;
                o_push.first = '{out_byte: w_value, out_last: w_end};
                n_phase      = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (w_byte == CH_PLUS) begin
                    o_push.count = 2'd1;
                    o_push.first = '{out_byte: CH_SPACE, out_last: w_end};
                end else if (w_byte == CH_PERCENT && !w_end) begin
                    n_phase = PH_PCT;
                end else begin
                    o_push.count = 2'd1;
                    o_push.first = '{out_byte: w_byte, out_last: w_end};
                end
            end
        endcase
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== rtl/upd_out_queue.sv =====
// Small output queue: up to two results in per cycle, one out unless stalled.
module upd_out_queue
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_upd_push i_push,
    output logic      o_room,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    t_out_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;
    logic [QUEUE_AW-1:0]   w_wr_next;
    logic                  w_pop;

    assign o_out_valid = (r_count != '0);
    assign o_out       = r_mem[r_rd_ptr];
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_wr_next   = r_wr_ptr + QUEUE_AW'(1);

    // Room for a worst-case pair, judged on the registered count alone.
    assign o_room = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_AW'(i_push.count);
        n_rd_ptr = w_pop ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count + QUEUE_CW'(i_push.count) - QUEUE_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
// Usage: raw bytes of an encoded string enter on the input channel (i_in_valid, i_in,
// o_in_stall), one per transaction, with end_of_string set on the final byte.
// Decoded bytes leave on the output channel (o_out_valid, o_out, i_out_stall), with
// out_last set on the final decoded byte of each string. A plus becomes a space and a
// percent sign with two following bytes becomes one byte; a percent sign cut short by
// the end of the string passes through literally.
// Path: a byte is held in the input register, decoded combinationally and written
// into the four-entry output queue, which offers results from registered state.
// Throughput: one input byte per cycle. A byte that yields two results (a percent sign
// followed by a final byte) always comes right after one that yields none, so the queue
// keeps pace and the input stalls only when the receiver stalls.
// Reset (synchronous, active low) empties the queue, drops any held input byte and
// clears a pending escape. When the receiver stalls, the queue fills and o_in_stall
// rises while a byte is held and fewer than two entries are free; nothing is lost or reordered.
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      w_room;
    logic      w_fire;
    t_upd_push w_push;

    assign w_fire     = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    upd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .o_push  (w_push)
    );

    upd_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule
